// ===== hw/rtl/pn2f_pkg.sv =====
package pn2f_pkg;

   // fixed point format of coordinates and results
   localparam int FRAC_BITS  = 16;
   localparam int ONE        = 1 << FRAC_BITS;
   localparam int COORD_W    = 24;
   localparam int TOTAL_W    = 18;
   localparam int HEIGHT_W   = 8;
   localparam int TOTAL_MAX  = 131071;
   localparam int TOTAL_MIN  = -131072;

   // permutation table
   localparam int TABLE_SIZE = 256;
   localparam int IDX_W      = $clog2(TABLE_SIZE);

   // octave count register
   localparam int OCT_W      = 4;
   localparam logic [OCT_W-1:0] OCT_RESET = 4'd4;

   // datapath widths
   localparam int SQ_W    = 2 * FRAC_BITS;
   localparam int P_W     = FRAC_BITS + 4;
   localparam int FADE_W  = FRAC_BITS + 1;
   localparam int GIN_W   = FRAC_BITS + 2;
   localparam int GRAD_W  = FRAC_BITS + 3;
   localparam int LERP_W  = FRAC_BITS + 5;
   localparam int NOISE_W = LERP_W;
   localparam int HT_W    = FRAC_BITS + 2;

   // item kinds
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   // gradient selectors
   localparam logic [1:0] GRAD_PP = 2'd0;
   localparam logic [1:0] GRAD_NP = 2'd1;
   localparam logic [1:0] GRAD_PN = 2'd2;
   localparam logic [1:0] GRAD_NN = 2'd3;

   typedef struct packed {
      logic                      op;
      logic [IDX_W-1:0]          table_index;
      logic [7:0]                table_value;
      logic signed [COORD_W-1:0] x_coord;
      logic signed [COORD_W-1:0] y_coord;
   } req_type;

   typedef struct packed {
      logic signed [TOTAL_W-1:0] noise_total;
      logic [HEIGHT_W-1:0]       height;
   } rsp_type;

   // diagonal gradient dot product
   function automatic logic signed [GRAD_W-1:0] grad(input logic [1:0] h,
                                                     input logic signed [GIN_W-1:0] gx,
                                                     input logic signed [GIN_W-1:0] gy);
      logic signed [GRAD_W-1:0] ex;
      logic signed [GRAD_W-1:0] ey;
      ex = GRAD_W'(gx);
      ey = GRAD_W'(gy);
      case (h)
         GRAD_PP: grad = ex + ey;
         GRAD_NP: grad = ey - ex;
         GRAD_PN: grad = ex - ey;
         default: grad = -ex - ey;
      endcase
   endfunction

   // a + floor(t * (b - a) / ONE)
   function automatic logic signed [LERP_W-1:0] lerp(input logic [FADE_W-1:0] t,
                                                     input logic signed [LERP_W-1:0] a,
                                                     input logic signed [LERP_W-1:0] b);
      logic signed [LERP_W:0]          diff;
      logic signed [LERP_W+FADE_W+1:0] prod;
      diff = (LERP_W+1)'(b) - (LERP_W+1)'(a);
      prod = $signed({1'b0, t}) * diff;
      lerp = a + LERP_W'(prod >>> FRAC_BITS);
   endfunction

endpackage

// ===== hw/rtl/pn2f_ram.sv =====
module pn2f_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr0,
   input  logic [$clog2(DEPTH)-1:0] raddr1,
   output logic [WIDTH-1:0]         rdata0,
   output logic [WIDTH-1:0]         rdata1
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata0_ff;
   logic [WIDTH-1:0] rdata1_ff;

   // one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata0_ff <= mem_ff[raddr0];
         rdata1_ff <= mem_ff[raddr1];
      end
   end

   assign rdata0 = rdata0_ff;
   assign rdata1 = rdata1_ff;

endmodule

// ===== hw/rtl/perlin_noise_2d_fbm.sv =====
// Fractal 2D gradient noise, one octave lane per MAX_OCTAVES, fully pipelined.
// Throughput: one beat per cycle; the whole pipeline advances together and only
// holds while the result register is full and stalled.
// Reset clears the valid bits and sets the octave count to 4; the permutation
// table copies are not cleared and must be loaded before use.
module perlin_noise_2d_fbm #(
   parameter int MAX_OCTAVES = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  pn2f_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output pn2f_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [pn2f_pkg::OCT_W-1:0]       csr_data
);
   import pn2f_pkg::*;

   localparam int NCW = $clog2(MAX_OCTAVES + 1);
   localparam int NIW = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
   localparam int DW  = MAX_OCTAVES;
   localparam int AW  = NOISE_W + MAX_OCTAVES;
   localparam int RW  = AW + 1;
   localparam int QW  = AW + MAX_OCTAVES + 1;
   localparam logic signed [AW-1:0] T_MAX = AW'(TOTAL_MAX);
   localparam logic signed [AW-1:0] T_MIN = AW'(TOTAL_MIN);

   logic adv;

   // octave count register
   logic [OCT_W-1:0] oct_ff;
   logic [NCW-1:0]   n_eff;
   logic [NIW-1:0]   n_idx;
   logic [DW-1:0]    dval;

   always_ff @(posedge clock) begin
      if (reset) begin
         oct_ff <= OCT_RESET;
      end else if (csr_valid) begin
         oct_ff <= csr_data;
      end
   end

   assign csr_ready = 1'b1;

   always_comb begin
      if (oct_ff == '0) begin
         n_eff = NCW'(1);
      end else if (int'(oct_ff) > MAX_OCTAVES) begin
         n_eff = NCW'(MAX_OCTAVES);
      end else begin
         n_eff = NCW'(oct_ff);
      end
   end

   assign n_idx = NIW'(n_eff - NCW'(1));
   assign dval  = DW'((65'd1 << n_eff) - 65'd1);

   // reciprocals of 2^n - 1, scaled by 2^AW
   logic [RW-1:0] recip [MAX_OCTAVES];
   for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_recip
      localparam longint unsigned RC = (64'd1 << AW) / ((64'd1 << (i + 1)) - 64'd1);
      assign recip[i] = RC[RW-1:0];
   end

   // global advance: hold only while the result is full and stalled
   logic rsp_valid_ff;
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // input stage
   logic    s0_valid_ff;
   req_type s0_ff;

   // stage 1 load info for the second table level
   logic             s1_valid_ff;
   logic             s1_op_ff;
   logic [IDX_W-1:0] s1_idx_ff;
   logic [7:0]       s1_val_ff;

   // evaluate valids of later stages
   logic v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;

   logic signed [NOISE_W-1:0] noise6_ff [MAX_OCTAVES];

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         v2_ff       <= 1'b0;
         v3_ff       <= 1'b0;
         v4_ff       <= 1'b0;
         v5_ff       <= 1'b0;
         v6_ff       <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= req_valid;
         s1_valid_ff <= s0_valid_ff;
         v2_ff       <= s1_valid_ff && (s1_op_ff == OP_EVAL);
         v3_ff       <= v2_ff;
         v4_ff       <= v3_ff;
         v5_ff       <= v4_ff;
         v6_ff       <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ff     <= req_data;
         s1_op_ff  <= s0_ff.op;
         s1_idx_ff <= s0_ff.table_index;
         s1_val_ff <= s0_ff.table_value;
      end
   end

   logic load0, load1;
   assign load0 = adv && s0_valid_ff && (s0_ff.op == OP_LOAD);
   assign load1 = adv && s1_valid_ff && (s1_op_ff == OP_LOAD);

   // one noise lane per octave
   for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_lane
      logic [COORD_W-1:0]   xl, yl;
      logic [IDX_W-1:0]     xi, yi;
      logic [IDX_W-1:0]     pa, pb, a_in, b_in;
      logic [IDX_W-1:0]     haa, hab, hba, hbb;
      logic [FRAC_BITS-1:0] t2x, t2y;
      logic [SQ_W-1:0]      t3x_in, t3y_in;
      logic [FRAC_BITS+P_W-1:0] fx_prod, fy_prod;
      logic [P_W-1:0]       px_in, py_in;
      logic signed [GIN_W-1:0] gx0, gx1, gy0, gy1;

      logic [IDX_W-1:0]     yi1_ff;
      logic [FRAC_BITS-1:0] fx1_ff, fy1_ff, fx2_ff, fy2_ff;
      logic [SQ_W-1:0]      sqx2_ff, sqy2_ff;
      logic [FRAC_BITS-1:0] t3x_ff, t3y_ff;
      logic [P_W-1:0]       px_ff, py_ff;
      logic signed [GRAD_W-1:0] gaa3_ff, gab3_ff, gba3_ff, gbb3_ff;
      logic signed [GRAD_W-1:0] gaa4_ff, gab4_ff, gba4_ff, gbb4_ff;
      logic [FADE_W-1:0]    u4_ff, v4f_ff, v5f_ff;
      logic signed [LERP_W-1:0] l1_ff, l2_ff;

      // octave coordinate: low bits of x * 2^k give cell and fraction
      assign xl = COORD_W'($unsigned(s0_ff.x_coord) << k);
      assign yl = COORD_W'($unsigned(s0_ff.y_coord) << k);
      assign xi = xl[FRAC_BITS +: IDX_W];
      assign yi = yl[FRAC_BITS +: IDX_W];

      // first table level: P[X], P[X+1]
      pn2f_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram_x (
         .clock  (clock),
         .we     (load0),
         .waddr  (s0_ff.table_index),
         .wdata  (s0_ff.table_value),
         .re     (adv),
         .raddr0 (xi),
         .raddr1 (xi + IDX_W'(1)),
         .rdata0 (pa),
         .rdata1 (pb)
      );

      assign a_in = pa + yi1_ff;
      assign b_in = pb + yi1_ff;

      // second table level: P[A], P[A+1], P[B], P[B+1]
      pn2f_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram_a (
         .clock  (clock),
         .we     (load1),
         .waddr  (s1_idx_ff),
         .wdata  (s1_val_ff),
         .re     (adv),
         .raddr0 (a_in),
         .raddr1 (a_in + IDX_W'(1)),
         .rdata0 (haa),
         .rdata1 (hab)
      );

      pn2f_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram_b (
         .clock  (clock),
         .we     (load1),
         .waddr  (s1_idx_ff),
         .wdata  (s1_val_ff),
         .re     (adv),
         .raddr0 (b_in),
         .raddr1 (b_in + IDX_W'(1)),
         .rdata0 (hba),
         .rdata1 (hbb)
      );

      // fade polynomial pieces
      assign t2x    = sqx2_ff[FRAC_BITS +: FRAC_BITS];
      assign t2y    = sqy2_ff[FRAC_BITS +: FRAC_BITS];
      assign t3x_in = t2x * fx2_ff;
      assign t3y_in = t2y * fy2_ff;
      assign px_in  = P_W'(6 * int'(t2x) - 15 * int'(fx2_ff) + 10 * ONE);
      assign py_in  = P_W'(6 * int'(t2y) - 15 * int'(fy2_ff) + 10 * ONE);
      assign fx_prod = t3x_ff * px_ff;
      assign fy_prod = t3y_ff * py_ff;

      // corner offsets for the gradients
      assign gx0 = $signed({2'b00, fx2_ff});
      assign gy0 = $signed({2'b00, fy2_ff});
      assign gx1 = gx0 - GIN_W'(ONE);
      assign gy1 = gy0 - GIN_W'(ONE);

      always_ff @(posedge clock) begin
         if (adv) begin
            // stage 1
            yi1_ff  <= yi;
            fx1_ff  <= xl[FRAC_BITS-1:0];
            fy1_ff  <= yl[FRAC_BITS-1:0];
            // stage 2
            fx2_ff  <= fx1_ff;
            fy2_ff  <= fy1_ff;
            sqx2_ff <= fx1_ff * fx1_ff;
            sqy2_ff <= fy1_ff * fy1_ff;
            // stage 3
            t3x_ff  <= t3x_in[FRAC_BITS +: FRAC_BITS];
            t3y_ff  <= t3y_in[FRAC_BITS +: FRAC_BITS];
            px_ff   <= px_in;
            py_ff   <= py_in;
            gaa3_ff <= grad(haa[1:0], gx0, gy0);
            gba3_ff <= grad(hba[1:0], gx1, gy0);
            gab3_ff <= grad(hab[1:0], gx0, gy1);
            gbb3_ff <= grad(hbb[1:0], gx1, gy1);
            // stage 4
            u4_ff   <= fx_prod[FRAC_BITS +: FADE_W];
            v4f_ff  <= fy_prod[FRAC_BITS +: FADE_W];
            gaa4_ff <= gaa3_ff;
            gba4_ff <= gba3_ff;
            gab4_ff <= gab3_ff;
            gbb4_ff <= gbb3_ff;
            // stage 5
            l1_ff   <= lerp(u4_ff, LERP_W'(gaa4_ff), LERP_W'(gba4_ff));
            l2_ff   <= lerp(u4_ff, LERP_W'(gab4_ff), LERP_W'(gbb4_ff));
            v5f_ff  <= v4f_ff;
            // stage 6
            noise6_ff[k] <= lerp(v5f_ff, l1_ff, l2_ff);
         end
      end
   end

   // weighted octave sum, one Horner step per stage: acc = 2*acc + noise[j] while j < n_eff, else acc passes on
   logic                      hv_ff  [MAX_OCTAVES];
   logic signed [AW-1:0]      hacc_ff [MAX_OCTAVES];
   logic signed [NOISE_W-1:0] hnz_ff [MAX_OCTAVES][MAX_OCTAVES];

   for (genvar j = 0; j < MAX_OCTAVES; j++) begin : g_sum
      logic signed [AW-1:0]      acc_prev;
      logic signed [NOISE_W-1:0] nz;
      logic                      v_prev;
      logic signed [AW-1:0]      hacc_in;

      if (j == 0) begin : g_first
         assign acc_prev = '0;
         assign nz       = noise6_ff[0];
         assign v_prev   = v6_ff;
         always_ff @(posedge clock) begin
            if (adv) begin
               hnz_ff[0] <= noise6_ff;
            end
         end
      end else begin : g_next
         assign acc_prev = hacc_ff[j-1];
         assign nz       = hnz_ff[j-1][j];
         assign v_prev   = hv_ff[j-1];
         always_ff @(posedge clock) begin
            if (adv) begin
               hnz_ff[j] <= hnz_ff[j-1];
            end
         end
      end

      assign hacc_in = (NCW'(j) < n_eff) ? (acc_prev <<< 1) + AW'(nz) : acc_prev;

      always_ff @(posedge clock) begin
         if (reset) begin
            hv_ff[j] <= 1'b0;
         end else if (adv) begin
            hv_ff[j] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            hacc_ff[j] <= hacc_in;
         end
      end
   end

   // floor division by 2^n - 1 via reciprocal and one correction step
   logic signed [AW-1:0]   acc_end;
   logic [AW-1:0]          m1_in;
   logic                   d1_valid_ff, d2_valid_ff, d3_valid_ff, d4_valid_ff;
   logic                   neg1_ff, neg2_ff, neg3_ff;
   logic [AW-1:0]          m1_ff, m2_ff;
   logic [AW+RW-1:0]       prod2_ff;
   logic [AW-1:0]          q0;
   logic [QW-1:0]          q0d;
   logic [QW-1:0]          r_full_in;
   logic [AW-1:0]          q3_ff;
   logic [DW:0]            r3_ff;
   logic [AW-1:0]          q4;
   logic signed [AW-1:0]   total_in;
   logic signed [AW-1:0]   total4_ff;

   assign acc_end = hacc_ff[MAX_OCTAVES-1];
   assign m1_in   = acc_end[AW-1] ?
                    AW'($unsigned(-acc_end)) + AW'(dval) - AW'(1) :
                    AW'($unsigned(acc_end));
   assign q0        = prod2_ff[AW +: AW];
   assign q0d       = (QW'(q0) << n_eff) - QW'(q0);
   assign r_full_in = QW'(m2_ff) - q0d;
   assign q4        = (r3_ff >= (DW+1)'(dval)) ? q3_ff + AW'(1) : q3_ff;
   assign total_in  = neg3_ff ? -$signed(q4) : $signed(q4);

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_valid_ff <= 1'b0;
         d2_valid_ff <= 1'b0;
         d3_valid_ff <= 1'b0;
         d4_valid_ff <= 1'b0;
      end else if (adv) begin
         d1_valid_ff <= hv_ff[MAX_OCTAVES-1];
         d2_valid_ff <= d1_valid_ff;
         d3_valid_ff <= d2_valid_ff;
         d4_valid_ff <= d3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         neg1_ff   <= acc_end[AW-1];
         m1_ff     <= m1_in;
         neg2_ff   <= neg1_ff;
         m2_ff     <= m1_ff;
         prod2_ff  <= m1_ff * recip[n_idx];
         neg3_ff   <= neg2_ff;
         q3_ff     <= q0;
         r3_ff     <= (DW+1)'(r_full_in);
         total4_ff <= total_in;
      end
   end

   // saturation and height byte, both from the unsaturated total
   logic signed [TOTAL_W-1:0] sat_in;
   logic signed [AW:0]        tp;
   logic [HT_W+7:0]           hprod;
   logic [HEIGHT_W-1:0]       height_in;
   rsp_type                   rsp_ff;

   always_comb begin
      if (total4_ff > T_MAX) begin
         sat_in = TOTAL_W'(TOTAL_MAX);
      end else if (total4_ff < T_MIN) begin
         sat_in = TOTAL_W'(TOTAL_MIN);
      end else begin
         sat_in = TOTAL_W'(total4_ff);
      end
   end

   assign tp    = (AW+1)'(total4_ff) + (AW+1)'(ONE);
   assign hprod = {tp[HT_W-1:0], 8'd0} - (HT_W+8)'(tp[HT_W-1:0]);

   always_comb begin
      if (tp[AW]) begin
         height_in = '0;
      end else if (tp >= (AW+1)'(1 << HT_W)) begin
         height_in = '1;
      end else if (hprod[HT_W+7:HT_W-1] > 9'd255) begin
         height_in = '1;
      end else begin
         height_in = hprod[HT_W-1 +: HEIGHT_W];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= d4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff.noise_total <= sat_in;
         rsp_ff.height      <= height_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_div_corr: assert property (@(posedge clock) disable iff (reset)
      d2_valid_ff |-> (r_full_in < (QW'(dval) << 1)))
      else $error("reciprocal quotient off by more than one");

   a_oct_range: assert property (@(posedge clock) disable iff (reset)
      (n_eff != '0) && (int'(n_eff) <= MAX_OCTAVES))
      else $error("effective octave count out of range");

   a_hold_noise: assert property (@(posedge clock) disable iff (reset)
      (v6_ff && !adv) |=> (v6_ff && $stable(noise6_ff[0])))
      else $error("noise stage changed while held");

   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(d4_valid_ff))
      else $error("result without an item in the last divide stage");

endmodule

// ===== verif/tb_perlin_noise_2d_fbm.sv =====
`timescale 1ns / 100ps

module tb_perlin_noise_2d_fbm;
   import pn2f_pkg::*;

   localparam int  LATENCY     = 19;
   localparam int  DRAIN_WAIT  = LATENCY + 12;
   localparam int  REQ_W       = $bits(req_type);
   localparam longint CYCLE_LIMIT = 400000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic [OCT_W-1:0] csr_data;

   // predictor state
   logic [7:0]       perm_copy [TABLE_SIZE];
   logic [OCT_W-1:0] octave_setting;
   rsp_type          expected_noise [$];

   bit     quiet_mode;
   bit     failed;
   longint cycle_count;

   perlin_noise_2d_fbm dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // ---------------- predictor ----------------
   function automatic longint fade_curve(longint t);
      longint t2, t3, p;
      t2 = (t * t) >>> FRAC_BITS;
      t3 = (t2 * t) >>> FRAC_BITS;
      p  = 6 * t2 - 15 * t + 10 * longint'(ONE);
      return (t3 * p) >>> FRAC_BITS;
   endfunction

   function automatic longint blend(longint t, longint a, longint b);
      return a + ((t * (b - a)) >>> FRAC_BITS);
   endfunction

   function automatic longint corner_grad(logic [7:0] h, longint gx, longint gy);
      case (h[1:0])
         GRAD_PP: return gx + gy;
         GRAD_NP: return gy - gx;
         GRAD_PN: return gx - gy;
         default: return -gx - gy;
      endcase
   endfunction

   function automatic longint octave_noise(longint xs, longint ys);
      longint cx, cy, fx, fy, u, v, l1, l2;
      logic [7:0] xi, yi, haa, hab, hba, hbb;
      int a, b;
      cx = xs >>> FRAC_BITS;
      cy = ys >>> FRAC_BITS;
      fx = xs - (cx <<< FRAC_BITS);
      fy = ys - (cy <<< FRAC_BITS);
      xi = cx[7:0];
      yi = cy[7:0];
      u  = fade_curve(fx);
      v  = fade_curve(fy);
      a  = int'(perm_copy[xi]) + int'(yi);
      b  = int'(perm_copy[8'(xi + 8'd1)]) + int'(yi);
      haa = perm_copy[a % TABLE_SIZE];
      hab = perm_copy[(a + 1) % TABLE_SIZE];
      hba = perm_copy[b % TABLE_SIZE];
      hbb = perm_copy[(b + 1) % TABLE_SIZE];
      l1 = blend(u, corner_grad(haa, fx, fy), corner_grad(hba, fx - ONE, fy));
      l2 = blend(u, corner_grad(hab, fx, fy - ONE), corner_grad(hbb, fx - ONE, fy - ONE));
      return blend(v, l1, l2);
   endfunction

   function automatic rsp_type eval_fbm(logic signed [COORD_W-1:0] xc,
                                        logic signed [COORD_W-1:0] yc);
      rsp_type r;
      int n;
      longint acc, den, total, sat, num, h;
      n = octave_setting;
      if (n < 1) n = 1;
      if (n > 8) n = 8;
      acc = 0;
      for (int k = 0; k < n; k++)
         acc += octave_noise(longint'(xc) <<< k, longint'(yc) <<< k) <<< (n - 1 - k);
      den = (longint'(1) <<< n) - 1;
      total = (acc >= 0) ? acc / den : -((-acc + den - 1) / den);
      sat = total;
      if (sat > TOTAL_MAX) sat = TOTAL_MAX;
      if (sat < TOTAL_MIN) sat = TOTAL_MIN;
      num = (total + ONE) * 255;
      h = (num < 0) ? 0 : num / (2 * ONE);
      if (h > 255) h = 255;
      r.noise_total = sat[TOTAL_W-1:0];
      r.height      = h[7:0];
      return r;
   endfunction

   // ---------------- drivers ----------------
   function automatic bit take_gap();
      return !quiet_mode && ($urandom_range(99) < 7);
   endfunction

   // send one beat; prediction happens on acceptance
   task automatic send_beat(req_type d);
      if (take_gap()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= d;
      do @(posedge clock); while (req_stall);
      if (d.op == OP_LOAD)
         perm_copy[d.table_index] = d.table_value;
      else
         expected_noise.push_back(eval_fbm(d.x_coord, d.y_coord));
   endtask

   task automatic send_load(logic [7:0] idx, logic [7:0] val);
      req_type d;
      d = REQ_W'({$urandom, $urandom, $urandom});
      d.op = OP_LOAD;
      d.table_index = idx;
      d.table_value = val;
      send_beat(d);
   endtask

   task automatic send_eval(logic [COORD_W-1:0] xc, logic [COORD_W-1:0] yc);
      req_type d;
      d = REQ_W'({$urandom, $urandom, $urandom});
      d.op = OP_EVAL;
      d.x_coord = xc;
      d.y_coord = yc;
      send_beat(d);
   endtask

   // drain the pipe so the register can be changed safely
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_noise.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_octaves(logic [OCT_W-1:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      octave_setting = value;
   endtask

   // ---------------- tests ----------------
   task automatic test_table_load();
      send_load(8'd0, 8'd255);
      send_load(8'd255, 8'd0);
      for (int i = 1; i < TABLE_SIZE - 1; i++)
         send_load(i[7:0], 8'($urandom));
   endtask

   task automatic test_extremes();
      send_eval(24'h000000, 24'h000000);
      send_eval(24'h7FFFFF, 24'h7FFFFF);
      send_eval(24'h800000, 24'h800000);
      send_eval(24'h7FFFFF, 24'h800000);
      send_eval(24'hFFFFFF, 24'h000001);
      send_eval(24'h00FFFF, 24'hFF0000);
      send_eval(24'h008000, 24'h008000);
      send_eval(24'h010000, 24'hFFFFFF);
      // load with an index at the top, then read around it
      send_load(8'd255, 8'd128);
      send_eval(24'hFF8000, 24'h7F8000);
   endtask

   task automatic test_octave_sweep();
      logic [OCT_W-1:0] settings [6] = '{4'd0, 4'd1, 4'd8, 4'd15, 4'd9, 4'd4};
      foreach (settings[i]) begin
         write_octaves(settings[i]);
         send_eval(24'h7FFFFF, 24'h800000);
         send_eval(24'h012345, 24'hFEDCBA);
         send_eval(24'($urandom), 24'($urandom));
      end
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 10)
            send_load(8'($urandom), 8'($urandom));
         else if ($urandom_range(3) == 0)
            send_eval(24'($signed(16'($urandom))) << $urandom_range(0, 4),
                      24'($signed(16'($urandom))) << $urandom_range(0, 4));
         else
            send_eval(24'($urandom), 24'($urandom));
      end
   endtask

   // ---------------- result check ----------------
   always @(posedge clock) begin
      rsp_stall <= take_gap();
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_noise.size() == 0) begin
            $display("%0t: unexpected beat noise_total=%0d height=%0d",
                     $time, rsp_data.noise_total, rsp_data.height);
            failed = 1'b1;
         end else begin
            rsp_type want;
            want = expected_noise.pop_front();
            if (rsp_data.noise_total !== want.noise_total) begin
               $display("%0t: noise_total expected %0d actual %0d",
                        $time, want.noise_total, rsp_data.noise_total);
               failed = 1'b1;
            end
            if (rsp_data.height !== want.height) begin
               $display("%0t: height expected %0d actual %0d",
                        $time, want.height, rsp_data.height);
               failed = 1'b1;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[perlin_noise_2d_fbm] ERROR");
         $finish;
      end
   end

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      rsp_stall   <= 1'b0;
      csr_valid   <= 1'b0;
      csr_data    <= '0;
      cycle_count <= 0;
      failed      = 1'b0;
      quiet_mode  = 1'b0;
      octave_setting = OCT_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_table_load();
      test_extremes();
      test_octave_sweep();
      write_octaves(4'd3);
      test_random(120);
      quiet_mode = 1'b1;
      write_octaves(4'd8);
      test_random(90);
      quiet_mode = 1'b0;
      write_octaves(4'd1);
      test_random(90);
      write_octaves(4'($urandom));
      test_random(120);

      wait_idle();
      if (!failed) begin
         $display("[perlin_noise_2d_fbm] OK");
      end else begin
         $display("[perlin_noise_2d_fbm] ERROR");
      end
      $finish;
   end

   // flag an error while more than 64 beats are waiting for their results
   always @(posedge clock) begin
      if (expected_noise.size() > 64 && !reset) begin
         $display("%0t: pending beats expected at most %0d actual %0d",
                  $time, 64, expected_noise.size());
         failed = 1'b1;
      end
   end

endmodule

// ===== sim.f =====
hw/rtl/pn2f_pkg.sv
hw/rtl/pn2f_ram.sv
hw/rtl/perlin_noise_2d_fbm.sv
verif/tb_perlin_noise_2d_fbm.sv
